@@ rtl/ltc_pkg.sv @@
// shared types and constants for the lru tag cache
// no dependencies

package ltc_pkg;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic hit;
        logic evicted;
    } ltc_flags_t;

endpackage

@@ rtl/ltc_cache_engine.sv @@
// tag store, valid bits, recency ranks and entry count with the lookup and update logic
// depends on ltc_pkg

module ltc_cache_engine #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ltc_pkg::CAP_BITS-1:0]       cfg_wdata,
    input  logic                               req_go,
    input  logic [KEY_BITS-1:0]                req_key,
    output ltc_pkg::ltc_flags_t                rsp_flags,
    output logic [$clog2(ENTRIES)-1:0]         rsp_slot,
    output logic [KEY_BITS-1:0]                rsp_evicted_key
);

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CW = (CNT_BITS > ltc_pkg::CAP_BITS) ? CNT_BITS : ltc_pkg::CAP_BITS;

    logic [KEY_BITS-1:0]         keys_reg  [ENTRIES];
    logic [IDX_BITS-1:0]         rank_reg  [ENTRIES];
    logic [IDX_BITS-1:0]         rank_next [ENTRIES];
    logic [IDX_BITS-1:0]         post_rank [ENTRIES];
    logic [ENTRIES-1:0]          valid_reg, valid_next;
    logic [CNT_BITS-1:0]         count_reg, count_next;
    logic [ltc_pkg::CAP_BITS-1:0] cap_reg;

    logic [ENTRIES-1:0]  match, ev_oh, free_oh, ins_oh, hit_ev_oh, miss_ev_oh;
    logic                hit, ev;
    logic [IDX_BITS-1:0] hit_rank;
    logic [CNT_BITS-1:0] cnt_m1;
    logic [CW-1:0]       ecap, count_w;

    always_comb begin
        if (cap_reg == '0) begin
            ecap = CW'(1);
        end else if (CW'(cap_reg) > CW'(ENTRIES)) begin
            ecap = CW'(ENTRIES);
        end else begin
            ecap = CW'(cap_reg);
        end
    end

    assign count_w = CW'(count_reg);
    assign cnt_m1  = count_reg - CNT_BITS'(1);

    always_comb begin
        match    = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (keys_reg[i] == req_key);
            if (match[i]) begin
                hit_rank = hit_rank | rank_reg[i];
            end
        end
        hit = |match;
    end

    // ranks after a hit, used to pick the victim of a hit
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                post_rank[i] = '0;
            end else if (valid_reg[i] && rank_reg[i] < hit_rank) begin
                post_rank[i] = rank_reg[i] + IDX_BITS'(1);
            end else begin
                post_rank[i] = rank_reg[i];
            end
            hit_ev_oh[i]  = valid_reg[i] && (CNT_BITS'(post_rank[i]) == cnt_m1);
            miss_ev_oh[i] = valid_reg[i] && (CNT_BITS'(rank_reg[i]) == cnt_m1);
        end
    end

    assign ev      = hit ? (count_w > ecap) : (count_w >= ecap);
    assign ev_oh   = ev ? (hit ? hit_ev_oh : miss_ev_oh) : '0;
    assign free_oh = ~valid_reg & (valid_reg + ENTRIES'(1));
    assign ins_oh  = ev ? ev_oh : free_oh;

    always_comb begin
        rsp_slot        = '0;
        rsp_evicted_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if ((hit && match[i]) || (!hit && ins_oh[i])) begin
                rsp_slot = rsp_slot | IDX_BITS'(i);
            end
            if (ev_oh[i]) begin
                rsp_evicted_key = rsp_evicted_key | keys_reg[i];
            end
        end
    end

    assign rsp_flags.hit     = hit;
    assign rsp_flags.evicted = ev;

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (hit) begin
            valid_next = valid_reg & ~ev_oh;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_next[i] = ev_oh[i] ? '0 : post_rank[i];
            end
            if (ev) begin
                count_next = count_reg - CNT_BITS'(1);
            end
        end else begin
            valid_next = valid_reg | ins_oh;
            for (int i = 0; i < ENTRIES; i++) begin
                if (ins_oh[i]) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
            end
            if (!ev) begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            cap_reg   <= ltc_pkg::CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (req_go) begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                for (int i = 0; i < ENTRIES; i++) begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_go && !hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (ins_oh[i]) begin
                    keys_reg[i] <= req_key;
                end
            end
        end
    end

endmodule

@@ rtl/lru_tag_cache_core.sv @@
// top level of the lru tag cache: input beat register, cache engine, result register
// depends on ltc_pkg and ltc_cache_engine

// Fully associative cache of ENTRIES keys with least-recently-used replacement.
// One key is taken per clock while the master side keeps up; its result passes the
// input and result registers and holds on the master side until taken. The whole
// lookup, victim choice and recency update run combinationally inside the engine
// between the input and result registers, so throughput is one beat per cycle under
// that condition. Valid bits and ranks clear at reset at once; no clearing pass is
// needed. The capacity register (1..16, reset 16, zero acts as 1) is to be written
// through cfg_we / cfg_wdata while the block is idle; the block does not enforce it.

module lru_tag_cache_core #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [ltc_pkg::CAP_BITS-1:0]           cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // key
    input  logic [((KEY_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // hit, slot, evicted, evicted_key
    output logic [((KEY_BITS + $clog2(ENTRIES) + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int OUT_BITS = KEY_BITS + IDX_BITS + 2;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic                in_valid_reg, in_valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg;
    logic                go;

    ltc_pkg::ltc_flags_t rsp_flags;
    logic [IDX_BITS-1:0] rsp_slot;
    logic [KEY_BITS-1:0] rsp_evicted_key;

    ltc_cache_engine #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_go          (go),
        .req_key         (key_reg),
        .rsp_flags       (rsp_flags),
        .rsp_slot        (rsp_slot),
        .rsp_evicted_key (rsp_evicted_key)
    );

    assign go       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (go) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            key_reg <= s_tdata[KEY_BITS-1:0];
        end
        if (go) begin
            out_data_reg <= OUT_W'({rsp_evicted_key, rsp_flags.evicted, rsp_slot,
                                    rsp_flags.hit});
        end
    end

endmodule
